// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Each macro samples on the rising edge of clk and is quiet during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AVHC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AVHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/avhc_pkg.sv -----
// Shared types, constants and the control program of the arc voltage height control.
// No dependencies; every module of this project imports this package.
`default_nettype none

package avhc_pkg;

  // Field and register widths
  localparam int VOLT_W    = 14;
  localparam int BAND_W    = 10;
  localparam int GAIN_W    = 9;
  localparam int DRIVE_W   = 14;
  localparam int PWM_W     = 8;
  localparam int CUR_W     = 10;
  localparam int STAT_W    = 3;
  localparam int AVG_W     = 24;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;

  // Datapath widths
  localparam int MUL_A_W   = 14;
  localparam int MUL_B_W   = 24;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int PROD_W    = 33;
  localparam int ACC_W     = 31;
  localparam int SUM_W     = PROD_W + 1;

  // Divider: quotient bits, numerator and divisor widths
  localparam int DIV_STEPS = 14;
  localparam int DEN_W     = 15;
  localparam int NUM_W     = DIV_STEPS + DEN_W;

  // Sequencer
  localparam int PC_W      = 4;

  // Register reset values
  localparam logic [VOLT_W-1:0]  REF_RESET  = 14'd1000;
  localparam logic [BAND_W-1:0]  BAND_RESET = 10'd10;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 9'd26;
  localparam logic [DRIVE_W-1:0] MAX_RESET  = 14'd10000;

  // Arithmetic constants
  localparam logic [GAIN_W-1:0]  GAIN_FULL  = 9'd256;
  localparam logic [PWM_W-1:0]   PWM_FULL   = 8'd255;
  // floor(3*x/44) == (x * 142989) >> 21 for every 14-bit x
  localparam logic [17:0]        CUR_MULT   = 18'd142989;
  localparam int                 CUR_SHIFT  = 21;
  localparam logic [CUR_W-1:0]   CUR_MAX    = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFERENCE  = 2'd0,
    REG_DEAD_BAND  = 2'd1,
    REG_GAIN       = 2'd2,
    REG_MAX_OUTPUT = 2'd3
  } avhc_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_LOWER   = 3'd1,
    ST_RAISE   = 3'd2,
    ST_OPENING = 3'd3,
    ST_OFF     = 3'd4
  } avhc_status_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_LATCH     = 4'd1,
    OP_MUL_NEW   = 4'd2,
    OP_MUL_OLD   = 4'd3,
    OP_AVG       = 4'd4,
    OP_CLASSIFY  = 4'd5,
    OP_MUL_DRV   = 4'd6,
    OP_DIV_DRV   = 4'd7,
    OP_DIV_STEP  = 4'd8,
    OP_DRV_STORE = 4'd9,
    OP_MUL_CUR   = 4'd10,
    OP_PWM_PREP  = 4'd11,
    OP_DIV_PWM   = 4'd12,
    OP_PWM_STORE = 4'd13,
    OP_EMIT      = 4'd14
  } avhc_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    J_NEVER    = 3'd0,
    J_ALWAYS   = 3'd1,
    J_NO_IN    = 3'd2,
    J_DIV_BUSY = 3'd3,
    J_MAX_ZERO = 3'd4,
    J_OUT_FULL = 3'd5
  } avhc_cond_t;

  typedef struct packed {
    avhc_op_t         op;
    avhc_cond_t       cond;
    logic [PC_W-1:0]  target;
    logic             last;
  } avhc_ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic div_busy;
    logic max_zero;
    logic out_full;
  } avhc_flags_t;

  // Jump targets
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_DRV_LOOP = 4'd7;
  localparam logic [PC_W-1:0] PC_PWM_LOOP = 4'd12;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd14;

  // Control program: taken jump goes to target, else last returns to idle,
  // else the step counter advances.
  function automatic avhc_ctrl_t ucode(input logic [PC_W-1:0] pc);
    avhc_ctrl_t w;
    w = '{op: OP_NOP, cond: J_ALWAYS, target: PC_IDLE, last: 1'b0};
    case (pc)
      4'd0:  w = '{op: OP_LATCH,     cond: J_NO_IN,    target: PC_IDLE,     last: 1'b0};
      4'd1:  w = '{op: OP_MUL_NEW,   cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd2:  w = '{op: OP_MUL_OLD,   cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd3:  w = '{op: OP_AVG,       cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd4:  w = '{op: OP_CLASSIFY,  cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd5:  w = '{op: OP_MUL_DRV,   cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd6:  w = '{op: OP_DIV_DRV,   cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd7:  w = '{op: OP_DIV_STEP,  cond: J_DIV_BUSY, target: PC_DRV_LOOP, last: 1'b0};
      4'd8:  w = '{op: OP_DRV_STORE, cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd9:  w = '{op: OP_MUL_CUR,   cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd10: w = '{op: OP_PWM_PREP,  cond: J_MAX_ZERO, target: PC_EMIT,     last: 1'b0};
      4'd11: w = '{op: OP_DIV_PWM,   cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd12: w = '{op: OP_DIV_STEP,  cond: J_DIV_BUSY, target: PC_PWM_LOOP, last: 1'b0};
      4'd13: w = '{op: OP_PWM_STORE, cond: J_NEVER,    target: PC_IDLE,     last: 1'b0};
      4'd14: w = '{op: OP_EMIT,      cond: J_OUT_FULL, target: PC_EMIT,     last: 1'b1};
      default: w = '{op: OP_NOP,     cond: J_ALWAYS,   target: PC_IDLE,     last: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/avhc_sequencer.sv -----
// Step counter and control store: fetches one control word per cycle.
// Depends on avhc_pkg for the program, control word and flag types.
`default_nettype none

module avhc_sequencer (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire avhc_pkg::avhc_flags_t flags,
  output avhc_pkg::avhc_ctrl_t     ctrl
);
  import avhc_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            jump;

  // Fetch and pick the next step
  always_comb begin
    ctrl = ucode(pc);
    case (ctrl.cond)
      J_NEVER:    jump = 1'b0;
      J_ALWAYS:   jump = 1'b1;
      J_NO_IN:    jump = !flags.in_fire;
      J_DIV_BUSY: jump = flags.div_busy;
      J_MAX_ZERO: jump = flags.max_zero;
      J_OUT_FULL: jump = flags.out_full;
      default:    jump = 1'b1;
    endcase
    if (jump) begin
      pc_next = ctrl.target;
    end else if (ctrl.last) begin
      pc_next = PC_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/avhc_divider.sv -----
// Restoring divider, one quotient bit per step, for quotients below 2**DIV_STEPS.
// Depends on avhc_pkg for widths.
`default_nettype none

module avhc_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic                         step,
  input  wire logic [avhc_pkg::NUM_W-1:0]   numer,
  input  wire logic [avhc_pkg::DEN_W-1:0]   denom,
  output logic [avhc_pkg::DIV_STEPS-1:0]    quotient,
  output logic                              busy
);
  import avhc_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam int REM_W = DEN_W + 1;

  logic [CNT_W-1:0]     cnt;
  logic [REM_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DIV_STEPS-1:0] shreg;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  // Shift the next numerator bit in and test the divisor
  always_comb begin
    trial = {rem[DEN_W-1:0], shreg[DIV_STEPS-1]};
    fits  = trial >= {1'b0, den};
  end

  assign quotient = shreg;
  assign busy     = cnt > CNT_W'(1);

  // Step count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNT_W'(DIV_STEPS);
    end else if (step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= {1'b0, numer[NUM_W-1:DIV_STEPS]};
      shreg <= numer[DIV_STEPS-1:0];
      den   <= denom;
    end else if (step) begin
      rem   <= fits ? trial - {1'b0, den} : trial;
      shreg <= {shreg[DIV_STEPS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/avhc_datapath.sv -----
// Registers, shared multiplier, compare logic and output register of the controller.
// Depends on avhc_pkg and avhc_divider; driven by control words from avhc_sequencer.
`default_nettype none

module avhc_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire avhc_pkg::avhc_ctrl_t           ctrl,
  output avhc_pkg::avhc_flags_t               flags,
  input  wire logic                           cfg_write,
  input  wire logic [avhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [avhc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [avhc_pkg::VOLT_W-1:0]    arc_voltage,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [avhc_pkg::DRIVE_W-1:0]        drive_level,
  output logic [avhc_pkg::PWM_W-1:0]          pwm_duty,
  output logic [avhc_pkg::CUR_W-1:0]          current_estimate,
  output logic [avhc_pkg::STAT_W-1:0]         control_status,
  output logic                                arc_good,
  output logic                                arc_opening
);
  import avhc_pkg::*;

  // Configuration registers
  logic [VOLT_W-1:0]  ref_cfg;
  logic [BAND_W-1:0]  band_cfg;
  logic [GAIN_W-1:0]  gain_cfg;
  logic [DRIVE_W-1:0] max_cfg;

  // Working registers
  logic [VOLT_W-1:0]  volt;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc;
  logic [AVG_W-1:0]   avg;
  logic [VOLT_W-1:0]  use_volt;
  avhc_status_t       status;
  logic [DRIVE_W-1:0] drive;
  logic [CUR_W-1:0]   cur;
  logic [PWM_W-1:0]   pwm;

  // Derived values
  logic [GAIN_W-1:0]  gain_eff;
  logic [GAIN_W-1:0]  gain_rest;
  logic [VOLT_W-1:0]  ref_eff;
  logic [DEN_W-1:0]   twice;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [SUM_W-1:0]   avg_sum;
  logic [DEN_W-1:0]   drv_diff;
  logic [CUR_W:0]     cur_raw;

  // Range tests
  logic [AVG_W+1:0]   avg_x3;
  logic               avg_low;
  logic               avg_high;
  logic [VOLT_W+1:0]  volt_x3;
  logic [DEN_W-1:0]   volt_plus_band;
  logic [DEN_W-1:0]   ref_plus_band;
  logic               in_band;
  avhc_status_t       range_status;
  avhc_status_t       track_status;
  logic [VOLT_W-1:0]  track_volt;

  // Divider hookup
  logic                 div_load;
  logic                 div_step;
  logic [NUM_W-1:0]     div_numer;
  logic [DEN_W-1:0]     div_denom;
  logic [DIV_STEPS-1:0] div_quo;
  logic                 div_busy;

  logic in_fire;
  logic out_full;

  assign gain_eff  = (gain_cfg > GAIN_FULL) ? GAIN_FULL : gain_cfg;
  assign gain_rest = GAIN_FULL - gain_eff;
  assign ref_eff   = (ref_cfg == '0) ? VOLT_W'(1) : ref_cfg;
  assign twice     = {ref_eff, 1'b0};

  assign in_ready = ctrl.op == OP_LATCH;
  assign in_fire  = in_valid && in_ready;
  assign out_full = out_valid && !out_ready;

  assign flags = '{in_fire: in_fire, div_busy: div_busy,
                   max_zero: max_cfg == '0, out_full: out_full};

  // Shared multiplier operand select
  always_comb begin
    drv_diff = (DEN_W'(use_volt) < twice) ? twice - DEN_W'(use_volt) : '0;
    case (ctrl.op)
      OP_MUL_NEW: begin
        mul_a = MUL_A_W'(gain_eff);
        mul_b = MUL_B_W'({volt, 8'd0});
      end
      OP_MUL_OLD: begin
        mul_a = MUL_A_W'(gain_rest);
        mul_b = avg;
      end
      OP_MUL_DRV: begin
        mul_a = max_cfg;
        mul_b = MUL_B_W'(drv_diff);
      end
      OP_MUL_CUR: begin
        mul_a = drive;
        mul_b = MUL_B_W'(CUR_MULT);
      end
      OP_PWM_PREP: begin
        mul_a = drive;
        mul_b = MUL_B_W'(PWM_FULL);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // Average mix and classification of the sample
  always_comb begin
    avg_sum  = SUM_W'(acc) + SUM_W'(prod);
    avg_x3   = {1'b0, avg, 1'b0} + (AVG_W + 2)'(avg);
    avg_low  = avg_x3 < (AVG_W + 2)'({ref_eff, 8'd0});
    avg_high = avg > AVG_W'({ref_eff, 9'd0});
    volt_x3  = {1'b0, volt, 1'b0} + (VOLT_W + 2)'(volt);

    if (DEN_W'(volt) > twice) begin
      range_status = ST_OPENING;
    end else if (volt_x3 < (VOLT_W + 2)'(ref_eff)) begin
      range_status = ST_OFF;
    end else begin
      range_status = ST_OK;
    end

    volt_plus_band = DEN_W'(volt) + DEN_W'(band_cfg);
    ref_plus_band  = DEN_W'(ref_eff) + DEN_W'(band_cfg);
    in_band        = (DEN_W'(volt) < ref_plus_band) && (volt_plus_band > DEN_W'(ref_eff));
    track_volt     = in_band ? ref_eff : volt;
    if (track_volt == ref_eff) begin
      track_status = ST_OK;
    end else if (track_volt > ref_eff) begin
      track_status = ST_LOWER;
    end else begin
      track_status = ST_RAISE;
    end

    cur_raw = prod[CUR_SHIFT +: CUR_W + 1];
  end

  // Divider operands
  always_comb begin
    div_load  = (ctrl.op == OP_DIV_DRV) || (ctrl.op == OP_DIV_PWM);
    div_step  = ctrl.op == OP_DIV_STEP;
    if (ctrl.op == OP_DIV_PWM) begin
      div_numer = prod[NUM_W-1:0] + NUM_W'(max_cfg) - NUM_W'(1);
      div_denom = DEN_W'(max_cfg);
    end else begin
      div_numer = prod[NUM_W-1:0];
      div_denom = twice;
    end
  end

  avhc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .step     (div_step),
    .numer    (div_numer),
    .denom    (div_denom),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_cfg  <= REF_RESET;
      band_cfg <= BAND_RESET;
      gain_cfg <= GAIN_RESET;
      max_cfg  <= MAX_RESET;
    end else if (cfg_write) begin
      case (avhc_reg_t'(cfg_index))
        REG_REFERENCE:  ref_cfg  <= cfg_data[VOLT_W-1:0];
        REG_DEAD_BAND:  band_cfg <= cfg_data[BAND_W-1:0];
        REG_GAIN:       gain_cfg <= cfg_data[GAIN_W-1:0];
        REG_MAX_OUTPUT: max_cfg  <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Running average, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (ctrl.op == OP_AVG) begin
      avg <= avg_sum[AVG_W+7:8];
    end
  end

  // Working registers, one operation per control word
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LATCH: begin
        if (in_fire) begin
          volt <= arc_voltage;
        end
      end
      OP_MUL_NEW: prod <= mul_p[PROD_W-1:0];
      OP_MUL_OLD: begin
        acc  <= prod[ACC_W-1:0];
        prod <= mul_p[PROD_W-1:0];
      end
      OP_CLASSIFY: begin
        if (avg_low || avg_high) begin
          use_volt <= ref_eff;
          status   <= range_status;
        end else begin
          use_volt <= track_volt;
          status   <= track_status;
        end
      end
      OP_MUL_DRV: prod <= mul_p[PROD_W-1:0];
      OP_DRV_STORE: drive <= div_quo;
      OP_MUL_CUR: prod <= mul_p[PROD_W-1:0];
      OP_PWM_PREP: begin
        cur  <= cur_raw[CUR_W] ? CUR_MAX : cur_raw[CUR_W-1:0];
        prod <= mul_p[PROD_W-1:0];
        pwm  <= PWM_FULL;
      end
      OP_PWM_STORE: pwm <= PWM_FULL - div_quo[PWM_W-1:0];
      default: ;
    endcase
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_full) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !out_full) begin
      drive_level      <= drive;
      pwm_duty         <= pwm;
      current_estimate <= cur;
      control_status   <= status;
      arc_good         <= status == ST_OK;
      arc_opening      <= status == ST_OPENING;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/arc_voltage_height_control.sv -----
// Arc voltage torch height control: one arc voltage sample in, one drive result out.
//
// Input channel (in_valid/in_ready, arc_voltage) takes one sample in 0.1 V units
// per control tick. Output channel (out_valid/out_ready) gives drive_level,
// pwm_duty, current_estimate, control_status, arc_good and arc_opening.
// Configuration: cfg_write with cfg_index 0 reference, 1 dead band, 2 smoothing
// gain, 3 max output; write only while the block is idle.
// One sample is in flight at a time. A result is loaded into the output register
// once the sample has passed all sequencer steps (the PWM duty division is skipped
// with max output at zero), and the next sample can be taken in the cycle after.
// Each sample uses the bit-serial divider once for the drive and once for the
// PWM duty, plus thirteen other sequencer steps: sample latch, multiplies,
// compares, divider loads, result stores and the output load.
// Reset clears the running average, loads the register defaults and empties the
// output register. A stalled result stays in the output register; the sequencer
// holds on its emit step until that register frees up, and meanwhile in_ready is
// low once the next sample has been taken.
// Depends on avhc_pkg, avhc_sequencer, avhc_datapath and avhc_divider.
`default_nettype none

module arc_voltage_height_control (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [avhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [avhc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [avhc_pkg::VOLT_W-1:0]    arc_voltage,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [avhc_pkg::DRIVE_W-1:0]        drive_level,
  output logic [avhc_pkg::PWM_W-1:0]          pwm_duty,
  output logic [avhc_pkg::CUR_W-1:0]          current_estimate,
  output logic [avhc_pkg::STAT_W-1:0]         control_status,
  output logic                                arc_good,
  output logic                                arc_opening
);
  import avhc_pkg::*;

  avhc_ctrl_t  ctrl;
  avhc_flags_t flags;

  // Control store and step counter
  avhc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Arithmetic, registers and channel logic
  avhc_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .flags            (flags),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .arc_voltage      (arc_voltage),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .drive_level      (drive_level),
    .pwm_duty         (pwm_duty),
    .current_estimate (current_estimate),
    .control_status   (control_status),
    .arc_good         (arc_good),
    .arc_opening      (arc_opening)
  );

endmodule

`default_nettype wire

// ----- rtl/avhc_checker.sv -----
// Port-level assertions for the arc voltage height control, bound to the top level.
// Depends on avhc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module avhc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [avhc_pkg::DRIVE_W-1:0]   drive_level,
  input wire logic [avhc_pkg::PWM_W-1:0]     pwm_duty,
  input wire logic [avhc_pkg::STAT_W-1:0]    control_status,
  input wire logic                           arc_good,
  input wire logic                           arc_opening
);
  import avhc_pkg::*;

  // Stalled result holds
  `AVHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_level) && $stable(pwm_duty) && $stable(control_status), "result changed while stalled")

  // One sample in flight: no second transaction right after one is taken
  `AVHC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input ready right after a transaction")

  // Flags agree with the status code
  `AVHC_ASSERT_IMP(a_good_flag, out_valid, arc_good == (control_status == ST_OK), "arc_good disagrees with status")
  `AVHC_ASSERT_IMP(a_opening_flag, out_valid, arc_opening == (control_status == ST_OPENING), "arc_opening disagrees with status")

endmodule

bind arc_voltage_height_control avhc_checker u_avhc_checker (.*);

`default_nettype wire
